// ===== hdl/hpoly_pkg.sv =====
// ----------------------------------------------------------------------------
// HCTR polynomial hash package
// Shared types and constants for the GF(2^128) polynomial hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package hpoly_pkg;

    localparam int BLOCK_BITS = 128;
    localparam int WORD_BITS  = 64;
    localparam int MCNT_BITS  = $clog2(BLOCK_BITS);

    // Reduction byte for the reflected bit order.
    localparam logic [7:0] REDUCE_BYTE = 8'hE1;

    localparam logic [31:0] MAX_MSG_BYTES = 32'hFFFF_FFFF;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] CFG_KEY_HI   = 2'd0;
    localparam logic [1:0] CFG_KEY_LO   = 2'd1;
    localparam logic [1:0] CFG_TWEAK_HI = 2'd2;
    localparam logic [1:0] CFG_TWEAK_LO = 2'd3;

    typedef struct packed {
        logic       push_in;
        logic       push_tw;
        logic [3:0] tw_idx;
        logic       count_inc;
        logic       set_ovf;
        logic       load_buf;
        logic       load_len;
        logic       mul_step;
        logic       clear;
        logic       out_lo;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_last;
        logic fill_zero;
        logic count_max;
        logic ovf;
        logic mul_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/hpoly_datapath.sv =====
// ----------------------------------------------------------------------------
// HCTR polynomial hash datapath
// Block buffer, counters, configuration registers and a bit-serial
// GF(2^128) multiplier that folds one block into the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module hpoly_datapath
    import hpoly_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [WORD_BITS-1:0] i_cfg_data,
    input  wire logic [7:0]           i_data_byte,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output logic [WORD_BITS-1:0]      o_hash_word
);

    logic [BLOCK_BITS-1:0] r_key, r_tweak;
    logic [BLOCK_BITS-1:0] r_acc, n_acc;
    logic [BLOCK_BITS-1:0] r_buf, n_buf;
    logic [BLOCK_BITS-1:0] r_z, n_z;
    logic [BLOCK_BITS-1:0] r_p, n_p;
    logic [BLOCK_BITS-1:0] r_k, n_k;
    logic [MCNT_BITS-1:0]  r_mcnt, n_mcnt;
    logic [3:0]            r_fill, n_fill;
    logic [31:0]           r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic [7:0]            w_byte;
    logic [32:0]           w_len_bytes;
    logic [WORD_BITS-1:0]  w_len_word;

    // Length block: bit count of message plus tweak in the low word.
    assign w_len_bytes = {1'b0, r_count} + 33'd16;
    assign w_len_word  = {28'd0, w_len_bytes, 3'd0};

    assign w_byte = i_cmd.push_in ? i_data_byte : r_tweak[{~i_cmd.tw_idx, 3'b000} +: 8];

    always_comb begin
        n_acc   = r_acc;
        n_buf   = r_buf;
        n_z     = r_z;
        n_p     = r_p;
        n_k     = r_k;
        n_mcnt  = r_mcnt;
        n_fill  = r_fill;
        n_count = r_count;
        n_ovf   = r_ovf;

        if (i_cmd.push_in || i_cmd.push_tw) begin
            // Byte 0 of a block is the most significant byte.
            n_buf[{~r_fill, 3'b000} +: 8] = w_byte;
            n_fill = r_fill + 4'd1;
        end
        if (i_cmd.count_inc) begin
            n_count = r_count + 32'd1;
        end
        if (i_cmd.set_ovf) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.load_buf || i_cmd.load_len) begin
            n_z    = r_acc ^ (i_cmd.load_len ? {{WORD_BITS{1'b0}}, w_len_word} : r_buf);
            n_p    = '0;
            n_k    = r_key;
            n_mcnt = '0;
            n_buf  = '0;
        end
        if (i_cmd.mul_step) begin
            if (r_k[BLOCK_BITS-1]) begin
                n_p = r_p ^ r_z;
            end
            n_z = {1'b0, r_z[BLOCK_BITS-1:1]} ^
                  (r_z[0] ? {REDUCE_BYTE, {(BLOCK_BITS-8){1'b0}}} : '0);
            n_k    = {r_k[BLOCK_BITS-2:0], 1'b0};
            n_mcnt = r_mcnt + 1'b1;
            if (o_sts.mul_last) begin
                n_acc = n_p;
            end
        end
        if (i_cmd.clear) begin
            n_acc   = '0;
            n_buf   = '0;
            n_fill  = '0;
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_buf   <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_acc   <= n_acc;
            r_buf   <= n_buf;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_mcnt  <= n_mcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z <= n_z;
        r_p <= n_p;
        r_k <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_tweak <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HI:   r_key[BLOCK_BITS-1:WORD_BITS]   <= i_cfg_data;
                CFG_KEY_LO:   r_key[WORD_BITS-1:0]            <= i_cfg_data;
                CFG_TWEAK_HI: r_tweak[BLOCK_BITS-1:WORD_BITS] <= i_cfg_data;
                CFG_TWEAK_LO: r_tweak[WORD_BITS-1:0]          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_sts.fill_last = (r_fill == 4'd15);
    assign o_sts.fill_zero = (r_fill == 4'd0);
    assign o_sts.count_max = (r_count == MAX_MSG_BYTES);
    assign o_sts.ovf       = r_ovf;
    assign o_sts.mul_last  = (r_mcnt == {MCNT_BITS{1'b1}});

    // A too long message reports a zero hash.
    assign o_hash_word = r_ovf ? '0 :
                         (i_cmd.out_lo ? r_acc[WORD_BITS-1:0] : r_acc[BLOCK_BITS-1:WORD_BITS]);

endmodule

`default_nettype wire

// ===== hdl/hpoly_ctrl.sv =====
// ----------------------------------------------------------------------------
// HCTR polynomial hash controller
// Sequences byte absorption, tweak insertion, block folds and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module hpoly_ctrl
    import hpoly_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_op,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output logic      o_last,
    input  wire logic i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_TWEAK    = 3'd1;
    localparam logic [2:0] ST_FIN      = 3'd2;
    localparam logic [2:0] ST_LOAD_BUF = 3'd3;
    localparam logic [2:0] ST_LOAD_LEN = 3'd4;
    localparam logic [2:0] ST_MUL      = 3'd5;
    localparam logic [2:0] ST_OUT_HI   = 3'd6;
    localparam logic [2:0] ST_OUT_LO   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic [3:0] r_tcnt, n_tcnt;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_tcnt      = r_tcnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_last      = 1'b0;
        o_cmd.tw_idx = r_tcnt;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_FINISH) begin
                        n_tcnt  = '0;
                        n_state = ST_TWEAK;
                    end else if (i_sts.ovf) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.count_max) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.push_in   = 1'b1;
                        o_cmd.count_inc = 1'b1;
                        if (i_sts.fill_last) begin
                            n_ret   = ST_IDLE;
                            n_state = ST_LOAD_BUF;
                        end
                    end
                end
            end
            ST_TWEAK: begin
                o_cmd.push_tw = 1'b1;
                n_tcnt = r_tcnt + 4'd1;
                if (i_sts.fill_last) begin
                    n_ret   = (r_tcnt == 4'd15) ? ST_FIN : ST_TWEAK;
                    n_state = ST_LOAD_BUF;
                end else if (r_tcnt == 4'd15) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // A partly filled block is zero padded and folded first.
                if (!i_sts.fill_zero) begin
                    n_ret   = ST_LOAD_LEN;
                    n_state = ST_LOAD_BUF;
                end else begin
                    n_state = ST_LOAD_LEN;
                end
            end
            ST_LOAD_BUF: begin
                o_cmd.load_buf = 1'b1;
                n_state = ST_MUL;
            end
            ST_LOAD_LEN: begin
                o_cmd.load_len = 1'b1;
                n_ret   = ST_OUT_HI;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = r_ret;
                end
            end
            ST_OUT_HI: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_OUT_LO;
                end
            end
            ST_OUT_LO: begin
                o_out_valid  = 1'b1;
                o_last       = 1'b1;
                o_cmd.out_lo = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_tcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_tcnt  <= n_tcnt;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hctr_polynomial_hash_core.sv =====
// A message byte is accepted while idle; the byte that completes a 16-byte
// block starts the bit-serial GF(2^128) multiply (load + 128 steps), and no byte is taken until it is done.
// Sustained byte throughput is set by the one-bit-per-cycle multiplier.
// Finish: the accept, 16 tweak bytes, a padding check and up to three block
// folds, then two result words.
// Reset (synchronous, active low) clears the hash state, the key and the tweak.
// ----------------------------------------------------------------------------
// HCTR polynomial hash core
// Absorbs message bytes and returns the 128-bit GF(2^128) hash as two words.
// ----------------------------------------------------------------------------
`default_nettype none

module hctr_polynomial_hash_core
    import hpoly_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [WORD_BITS-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_op,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [WORD_BITS-1:0]      o_hash_word,
    output logic                      o_too_long,
    output logic                      o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;
    assign o_too_long  = w_sts.ovf;

    hpoly_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_last      (o_last),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hpoly_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_data_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_hash_word (o_hash_word)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last |=> o_in_ready && !o_too_long)
        else $error("state not cleared after the final hash word");

    a_too_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_long |-> o_hash_word == '0)
        else $error("too long message reported a nonzero hash");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_last)
        else $error("second hash word missing");

endmodule

`default_nettype wire

// ===== tb/hctr_polynomial_hash_core_test.sv =====
// ----------------------------------------------------------------------------
// HCTR polynomial hash core testbench
// Drives message bytes and finish transactions into the core with random gaps
// and back-pressure, and checks both hash words of every message against a
// GF(2^128) Horner predictor that tracks the key, tweak and hash state.
// ----------------------------------------------------------------------------
module hctr_polynomial_hash_core_test;
    import hpoly_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 4000000;
    localparam int SETTLE_CYCLES   = 150;
    localparam int HOLD_CYCLES     = 1500;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE  = 3;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic                 too_long;
        logic                 last;
    } t_hash_half;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [1:0]     idx;
        logic [63:0]    value;
        logic           op;
        logic [7:0]     data;
        logic [127:0]   hash;
    } t_dir_row;

    localparam int DIR_ROWS = 31;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index;
    logic [WORD_BITS-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_op;
    logic [7:0]           i_data_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [WORD_BITS-1:0] o_hash_word;
    logic                 o_too_long;
    logic                 o_last;

    // Predicted core state.
    logic [127:0] key_st;
    logic [127:0] tweak_st;
    logic [127:0] acc_st;
    logic [127:0] blk_st;
    logic [3:0]   fill_st;
    logic [32:0]  count_st;
    logic         ovf_st;

    t_hash_half pending_halves[$];
    int         fails = 0;
    int         cycles = 0;
    bit         in_gaps;
    bit         hold_req = 1'b0;

    // Rows of type ROW_TYPED carry the hash in the hash field; it can be
    // read off directly for a zero key or for the identity key (x^0).
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_TYPED, '0, '0, OP_FINISH, 8'hFF, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'hFF, 128'h0},
        '{ROW_TYPED, '0, '0, OP_FINISH, 8'h00, 128'h0},
        '{ROW_CFG, CFG_KEY_HI, 64'h8000_0000_0000_0000, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_CFG, CFG_KEY_LO, 64'h0, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_TYPED, '0, '0, OP_FINISH, 8'h3C, 128'h80},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'hA5, 128'h0},
        '{ROW_TYPED, '0, '0, OP_FINISH, 8'hC3,
          128'hA500_0000_0000_0000_0000_0000_0000_0088},
        '{ROW_CFG, CFG_TWEAK_HI, 64'hFFFF_FFFF_FFFF_FFFF, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_CFG, CFG_TWEAK_LO, 64'h0123_4567_89AB_CDEF, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_TYPED, '0, '0, OP_FINISH, 8'h5A,
          128'hFFFF_FFFF_FFFF_FFFF_0123_4567_89AB_CD6F},
        '{ROW_CFG, CFG_KEY_HI, 64'hFFFF_FFFF_FFFF_FFFF, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_CFG, CFG_KEY_LO, 64'hFFFF_FFFF_FFFF_FFFF, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h00, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'hFF, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h80, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h01, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h7F, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'hFE, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h55, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'hAA, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h0F, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'hF0, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h10, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h20, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h40, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h08, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h04, 128'h0},
        '{ROW_ITEM, '0, '0, OP_ABSORB, 8'h02, 128'h0},
        '{ROW_ITEM, '0, '0, OP_FINISH, 8'h99, 128'h0}
    };

    hctr_polynomial_hash_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hash_word (o_hash_word),
        .o_too_long  (o_too_long),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Reflected bit order: bit 127 of a vector is the coefficient of x^0.
    function automatic logic [127:0] gf128_mul(input logic [127:0] a, input logic [127:0] b);
        logic [127:0] z;
        logic [127:0] p;
        logic         lsb;
        z = a;
        p = '0;
        for (int i = 0; i < 128; i++) begin
            if (b[127-i]) begin
                p ^= z;
            end
            lsb = z[0];
            z = z >> 1;
            if (lsb) begin
                z[127:120] ^= REDUCE_BYTE;
            end
        end
        return p;
    endfunction

    function automatic void hash_fold(input logic [127:0] m);
        acc_st = gf128_mul(acc_st ^ m, key_st);
    endfunction

    function automatic void hash_push_byte(input logic [7:0] b);
        blk_st[127 - 8*fill_st -: 8] = b;
        if (fill_st == 4'd15) begin
            hash_fold(blk_st);
            blk_st = '0;
            fill_st = '0;
        end else begin
            fill_st++;
        end
    endfunction

    // Applies one accepted transaction to the predicted state and queues the
    // two hash words that a finish produces.
    function automatic void hash_accept(input logic op, input logic [7:0] b);
        logic [63:0]  len_bits;
        logic [127:0] hash;
        if (op == OP_ABSORB) begin
            if (ovf_st) begin
                return;
            end
            if (count_st >= {1'b0, MAX_MSG_BYTES}) begin
                ovf_st = 1'b1;
                return;
            end
            hash_push_byte(b);
            count_st++;
        end else begin
            for (int i = 0; i < 16; i++) begin
                hash_push_byte(tweak_st[127 - 8*i -: 8]);
            end
            if (fill_st != 0) begin
                hash_fold(blk_st);
            end
            len_bits = ({31'b0, count_st} + 64'd16) << 3;
            hash_fold({64'h0, len_bits});
            hash = ovf_st ? '0 : acc_st;
            pending_halves.push_back('{hash[127:64], ovf_st, 1'b0});
            pending_halves.push_back('{hash[63:0], ovf_st, 1'b1});
            acc_st = '0;
            blk_st = '0;
            fill_st = '0;
            count_st = '0;
            ovf_st = 1'b0;
        end
    endfunction

    function automatic logic [63:0] pick_reg_value(input int phase);
        if (phase == 0) begin
            return '1;
        end
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY_HI:   key_st[127:64]   = value;
            CFG_KEY_LO:   key_st[63:0]     = value;
            CFG_TWEAK_HI: tweak_st[127:64] = value;
            CFG_TWEAK_LO: tweak_st[63:0]   = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid is only lowered when a gap is taken, so back-to-back
    // transactions keep it high across the boundary.
    task automatic offer_item(input logic op, input logic [7:0] data);
        int gap;
        int r;
        gap = 0;
        if (in_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 97) begin
                gap = $urandom_range(10, 60);
            end else if (r >= 65) begin
                gap = $urandom_range(1, 3);
            end
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_in_ready);
        hash_accept(op, data);
    endtask

    task automatic quiet_in();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_halves.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_hash_half head;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_halves.size() == 0) begin
                $error("unexpected hash word %h", o_hash_word);
                fails++;
            end else begin
                head = pending_halves.pop_front();
                if (o_hash_word !== head.word) begin
                    $error("hash_word: expected %h, actual %h", head.word, o_hash_word);
                    fails++;
                end
                if (o_too_long !== head.too_long) begin
                    $error("too_long: expected %b, actual %b", head.too_long, o_too_long);
                    fails++;
                end
                if (o_last !== head.last) begin
                    $error("last: expected %b, actual %b", head.last, o_last);
                    fails++;
                end
            end
        end
    end

    // Result side: short random stalls, occasional long ones, calm stretches,
    // and one long hold on request so that the core backs up.
    initial begin
        int   busy_left;
        int   calm_left;
        int   hold_left;
        int   r;
        bit   hold_taken;
        logic nxt;
        busy_left = 0;
        calm_left = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b0;
            end else if (busy_left > 0) begin
                busy_left--;
                nxt = 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                nxt = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    busy_left = $urandom_range(20, 80);
                end else if (r < 5) begin
                    calm_left = $urandom_range(50, 300);
                end
                nxt = (r >= 30);
            end
            i_out_ready <= nxt;
        end
    end

    initial begin
        int         phase;
        int         phase_items;
        int         len;
        int         r;
        logic [7:0] data;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_op        = OP_ABSORB;
        i_data_byte = '0;
        in_gaps     = 1'b1;
        key_st      = '0;
        tweak_st    = '0;
        acc_st      = '0;
        blk_st      = '0;
        fill_st     = '0;
        count_st    = '0;
        ovf_st      = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[n]) begin
            if (dir_tab[n].kind == ROW_CFG) begin
                quiet_in();
                wait_drained();
                write_reg(dir_tab[n].idx, dir_tab[n].value);
            end else begin
                offer_item(dir_tab[n].op, dir_tab[n].data);
                if (dir_tab[n].kind == ROW_TYPED) begin
                    pending_halves[$-1].word = dir_tab[n].hash[127:64];
                    pending_halves[$].word   = dir_tab[n].hash[63:0];
                end
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            quiet_in();
            wait_drained();
            write_reg(CFG_KEY_HI, pick_reg_value(phase));
            write_reg(CFG_KEY_LO, pick_reg_value(phase));
            write_reg(CFG_TWEAK_HI, pick_reg_value(phase));
            write_reg(CFG_TWEAK_LO, pick_reg_value(phase));
            if (phase == PRESSURE_PHASE) begin
                hold_req = 1'b1;
            end
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                in_gaps = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (phase == PRESSURE_PHASE) begin
                    len = $urandom_range(0, 4);
                end else if (r < 60) begin
                    len = $urandom_range(0, 20);
                end else if (r < 90) begin
                    len = $urandom_range(21, 48);
                end else begin
                    len = $urandom_range(49, 96);
                end
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 9))
                        0: data = 8'h00;
                        1: data = 8'hFF;
                        default: data = 8'($urandom_range(0, 255));
                    endcase
                    offer_item(OP_ABSORB, data);
                end
                offer_item(OP_FINISH, 8'($urandom_range(0, 255)));
                phase_items += len + 1;
            end
        end

        quiet_in();
        wait_drained();
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== hctr_polynomial_hash_core.f =====
hdl/hpoly_pkg.sv
hdl/hpoly_datapath.sv
hdl/hpoly_ctrl.sv
hdl/hctr_polynomial_hash_core.sv
tb/hctr_polynomial_hash_core_test.sv
